FILE: hw/rtl/qau_pkg.sv
package qau_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // Magnitude of the tanh value in Q.30 as carried through the doubling chain.
    localparam int T_W       = 30;
    localparam int DIV_STEPS = T_W;
    localparam int DBL_ITERS = 8;

    localparam int MAG_W  = 8;
    localparam int X_W    = 24;
    localparam int A_W    = 26;
    localparam int A2_W   = 21;
    localparam int A3_W   = 16;
    localparam int A5_W   = 6;
    localparam int Y_W    = 15;
    localparam int Q_W    = 13;

    localparam logic [X_W-1:0] X_MAX     = 24'h80_0000;
    localparam logic [16:0]    RECIP3    = 17'd43691;
    localparam logic [6:0]     RECIP15   = 7'd69;
    localparam logic [30:0]    RND15     = 31'h0000_4000;
    localparam logic [39:0]    RND27     = 40'h00_0400_0000;

    localparam logic                    MODE_RELU   = 1'b0;
    localparam logic                    MODE_TANH   = 1'b1;
    localparam logic                    RST_MODE    = MODE_RELU;
    localparam logic signed [SAMPLE_W-1:0] RST_ZP   = 8'sd0;
    localparam logic [CFG_W-1:0]        RST_SCALE   = 24'd8192;
    localparam logic [CFG_W-1:0]        RST_INV     = 24'd524288;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_ZP    = 2'd1,
        CFG_SCALE = 2'd2,
        CFG_INV   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                       last;
        logic                       neg;
        logic signed [SAMPLE_W-1:0] relu;
    } t_side;

endpackage

FILE: hw/rtl/qau_front.sv
module qau_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [qau_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                  i_sample_last,
    input  logic signed [qau_pkg::SAMPLE_W-1:0]   i_zp,
    input  logic        [qau_pkg::CFG_W-1:0]      i_scale,
    output logic                                  o_valid,
    output logic        [qau_pkg::T_W-1:0]        o_t,
    output qau_pkg::t_side                        o_side
);
    import qau_pkg::*;

    logic [5:0] r_vld;
    t_side      r_side [0:5];

    logic [MAG_W-1:0] r1_mag;
    logic [A_W-1:0]   r2_a;
    logic [A_W-1:0]   r3_a;
    logic [A2_W-1:0]  r3_a2;
    logic [A_W-1:0]   r4_a;
    logic [A2_W-1:0]  r4_a2;
    logic [A3_W-1:0]  r4_a3;
    logic [A_W-1:0]   r5_a;
    logic [A5_W-1:0]  r5_a5;
    logic [A3_W-1:0]  r5_q3;
    logic [T_W-1:0]   r6_t;

    logic [SAMPLE_W:0]   w_d;
    logic [SAMPLE_W:0]   w_negd;
    logic                w_neg;
    t_side               w_side;
    logic [31:0]         w_x;
    logic [X_W-1:0]      w_xs;
    logic [2*A_W-1:0]    w_aa;
    logic [46:0]         w_p4;
    logic [36:0]         w_p5;
    logic [32:0]         w_p3;
    logic [13:0]         w_p15;
    logic [A_W-1:0]      w_t;

    assign w_d    = {i_sample[SAMPLE_W-1], i_sample} - {i_zp[SAMPLE_W-1], i_zp};
    assign w_negd = (SAMPLE_W+1)'(0) - w_d;
    assign w_neg  = w_d[SAMPLE_W];

    assign w_side.last = i_sample_last;
    assign w_side.neg  = w_neg;
    assign w_side.relu = (i_sample > i_zp) ? i_sample : i_zp;

    assign w_x   = 32'(r1_mag) * 32'(i_scale);
    assign w_xs  = (w_x > 32'(X_MAX)) ? X_MAX : w_x[X_W-1:0];
    assign w_aa  = (2*A_W)'(r2_a) * (2*A_W)'(r2_a);
    assign w_p4  = 47'(r3_a2) * 47'(r3_a);
    assign w_p5  = 37'(r4_a3) * 37'(r4_a2);
    assign w_p3  = 33'(r4_a3) * 33'(RECIP3);
    assign w_p15 = 14'({r5_a5, 1'b0}) * 14'(RECIP15);
    assign w_t   = r5_a - A_W'(r5_q3) + A_W'(w_p15[13:10]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= w_side;
            for (int k = 1; k < 6; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r1_mag <= w_neg ? w_negd[MAG_W-1:0] : w_d[MAG_W-1:0];
            r2_a   <= {w_xs, 2'b00};
            r3_a   <= r2_a;
            r3_a2  <= w_aa[50:30];
            r4_a   <= r3_a;
            r4_a2  <= r3_a2;
            r4_a3  <= w_p4[45:30];
            r5_a   <= r4_a;
            r5_a5  <= w_p5[35:30];
            r5_q3  <= w_p3[32:17];
            r6_t   <= T_W'(w_t);
        end
    end

    assign o_valid = r_vld[5];
    assign o_t     = r6_t;
    assign o_side  = r_side[5];

endmodule

FILE: hw/rtl/qau_dbl_iter.sv
module qau_dbl_iter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [qau_pkg::T_W-1:0]      i_t,
    input  qau_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [qau_pkg::T_W-1:0]      o_t,
    output qau_pkg::t_side               o_side
);
    import qau_pkg::*;

    logic               r_m_vld;
    logic [T_W-1:0]     r_m_t;
    logic [2*T_W-1:0]   r_m_sq;
    t_side              r_m_side;

    logic [T_W:0]       w_div0;
    logic [T_W:0]       w_rem0;

    logic               r_vld   [0:DIV_STEPS];
    t_side              r_side  [0:DIV_STEPS];
    logic               r_clamp [0:DIV_STEPS];
    logic [T_W-1:0]     r_quo   [0:DIV_STEPS];
    logic [T_W:0]       r_div   [0:DIV_STEPS-1];
    logic [T_W:0]       r_rem   [0:DIV_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (i_en) begin
            r_m_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_t    <= i_t;
            r_m_sq   <= (2*T_W)'(i_t) * (2*T_W)'(i_t);
            r_m_side <= i_side;
        end
    end

    // The dividend is t shifted up by 31, so its bits below the divisor's first
    // quotient bit are zero and the partial remainder starts as twice t.
    assign w_div0 = {1'b1, r_m_sq[2*T_W-1:T_W]};
    assign w_rem0 = {r_m_t, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0]  <= r_m_side;
            r_clamp[0] <= (w_rem0 >= w_div0);
            r_quo[0]   <= '0;
            r_div[0]   <= w_div0;
            r_rem[0]   <= w_rem0;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [T_W+1:0] w_sh;
        logic [T_W+1:0] w_diff;
        logic           w_ge;

        assign w_sh   = {r_rem[k-1], 1'b0};
        assign w_diff = w_sh - {1'b0, r_div[k-1]};
        assign w_ge   = (w_sh >= {1'b0, r_div[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k]  <= r_side[k-1];
                r_clamp[k] <= r_clamp[k-1];
                r_quo[k]   <= {r_quo[k-1][T_W-2:0], w_ge};
            end
        end

        if (k < DIV_STEPS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_div[k] <= r_div[k-1];
                    r_rem[k] <= w_ge ? w_diff[T_W:0] : w_sh[T_W:0];
                end
            end
        end
    end

    assign o_valid = r_vld[DIV_STEPS];
    assign o_t     = r_clamp[DIV_STEPS] ? '1 : r_quo[DIV_STEPS];
    assign o_side  = r_side[DIV_STEPS];

endmodule

FILE: hw/rtl/qau_back.sv
module qau_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic        [qau_pkg::T_W-1:0]        i_t,
    input  qau_pkg::t_side                        i_side,
    input  logic                                  i_mode,
    input  logic signed [qau_pkg::SAMPLE_W-1:0]   i_zp,
    input  logic        [qau_pkg::CFG_W-1:0]      i_inv,
    input  logic                                  i_stall,
    output logic                                  o_en,
    output logic                                  o_valid,
    output logic signed [qau_pkg::SAMPLE_W-1:0]   o_activated,
    output logic                                  o_activated_last
);
    import qau_pkg::*;

    logic                        r_b1_vld;
    logic [Y_W-1:0]              r_b1_y;
    t_side                       r_b1_side;
    logic                        r_b2_vld;
    logic [Q_W-1:0]              r_b2_q;
    t_side                       r_b2_side;

    logic                        r_out_vld;
    logic signed [SAMPLE_W-1:0]  r_out_act;
    logic                        r_out_last;
    logic                        r_skid_vld;
    logic signed [SAMPLE_W-1:0]  r_skid_act;
    logic                        r_skid_last;

    logic                        w_en;
    logic [30:0]                 w_rnd;
    logic [39:0]                 w_p;
    logic signed [Q_W:0]         w_qs;
    logic signed [Q_W+1:0]       w_sum;
    logic signed [SAMPLE_W-1:0]  w_sat;
    logic signed [SAMPLE_W-1:0]  w_res;
    logic                        w_in;
    logic                        w_take;

    assign w_en  = !r_skid_vld;
    assign w_rnd = {1'b0, i_t} + RND15;
    assign w_p   = 40'(r_b1_y) * 40'(i_inv) + RND27;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
        end else if (w_en) begin
            r_b1_vld <= i_valid;
            r_b2_vld <= r_b1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_y    <= w_rnd[30] ? '1 : w_rnd[29:15];
            r_b1_side <= i_side;
            r_b2_q    <= w_p[39:27];
            r_b2_side <= r_b1_side;
        end
    end

    always_comb begin
        w_qs  = r_b2_side.neg ? -$signed({1'b0, r_b2_q}) : $signed({1'b0, r_b2_q});
        w_sum = $signed({w_qs[Q_W], w_qs}) + $signed((Q_W+2)'(i_zp));
        if (w_sum > 15'sd127) begin
            w_sat = 8'sd127;
        end else if (w_sum < -15'sd128) begin
            w_sat = -8'sd128;
        end else begin
            w_sat = w_sum[SAMPLE_W-1:0];
        end
        w_res = (i_mode == MODE_TANH) ? w_sat : r_b2_side.relu;
    end

    // A beat leaving the pipeline goes to the output register when it is free
    // or being drained, and to the skid register otherwise.
    assign w_in   = w_en && r_b2_vld;
    assign w_take = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_in) begin
            if (!r_out_vld || w_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld  <= r_skid_vld;
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            if (!r_out_vld || w_take) begin
                r_out_act  <= w_res;
                r_out_last <= r_b2_side.last;
            end else begin
                r_skid_act  <= w_res;
                r_skid_last <= r_b2_side.last;
            end
        end else if (w_take && r_skid_vld) begin
            r_out_act  <= r_skid_act;
            r_out_last <= r_skid_last;
        end
    end

    assign o_en             = w_en;
    assign o_valid          = r_out_vld;
    assign o_activated      = r_out_act;
    assign o_activated_last = r_out_last;

endmodule

FILE: hw/rtl/quantized_activation_unit.sv
// Elementwise int8 activation, ReLU or tanh, one sample in and one result out
// per beat. A new sample is taken every clock cycle while the output side keeps
// up. The pipeline depth is set by the tanh path: six stages of scaling and
// polynomial, eight doubling rounds of 32 stages each (one squaring stage, one
// setup stage and a 30-stage bit-per-stage divider), two rounding stages and
// the output register. ReLU results travel the same pipeline so that order is
// kept. When the consumer stalls, an output register and a skid register hold
// results, and the input is stalled only while the skid register is full.
// Configuration writes are meant for times when no sample is in flight.
module quantized_activation_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [qau_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                                   i_sample_last,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [qau_pkg::SAMPLE_W-1:0]    o_activated,
    output logic                                   o_activated_last,
    input  logic                                   i_cfg_we,
    input  logic        [qau_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [qau_pkg::CFG_W-1:0]       i_cfg_data
);
    import qau_pkg::*;

    logic                        r_mode;
    logic signed [SAMPLE_W-1:0]  r_zp;
    logic [CFG_W-1:0]            r_scale;
    logic [CFG_W-1:0]            r_inv;

    logic                        w_en;
    logic                        w_vld  [0:DBL_ITERS];
    logic [T_W-1:0]              w_t    [0:DBL_ITERS];
    t_side                       w_side [0:DBL_ITERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_zp    <= RST_ZP;
            r_scale <= RST_SCALE;
            r_inv   <= RST_INV;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:  r_mode  <= i_cfg_data[0];
                CFG_ZP:    r_zp    <= i_cfg_data[SAMPLE_W-1:0];
                CFG_SCALE: r_scale <= i_cfg_data;
                CFG_INV:   r_inv   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    qau_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_valid),
        .i_sample      (i_sample),
        .i_sample_last (i_sample_last),
        .i_zp          (r_zp),
        .i_scale       (r_scale),
        .o_valid       (w_vld[0]),
        .o_t           (w_t[0]),
        .o_side        (w_side[0])
    );

    for (genvar g = 0; g < DBL_ITERS; g++) begin : g_dbl
        qau_dbl_iter u_dbl (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[g]),
            .i_t     (w_t[g]),
            .i_side  (w_side[g]),
            .o_valid (w_vld[g+1]),
            .o_t     (w_t[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    qau_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_vld[DBL_ITERS]),
        .i_t              (w_t[DBL_ITERS]),
        .i_side           (w_side[DBL_ITERS]),
        .i_mode           (r_mode),
        .i_zp             (r_zp),
        .i_inv            (r_inv),
        .i_stall          (i_stall),
        .o_en             (w_en),
        .o_valid          (o_valid),
        .o_activated      (o_activated),
        .o_activated_last (o_activated_last)
    );

    assign o_stall = !w_en;

endmodule

FILE: tb/sv/quantized_activation_unit_test.sv
module quantized_activation_unit_test;

    import qau_pkg::*;

    localparam int          CLK_PERIOD  = 20;
    localparam int          RESET_CYCLES = 12;
    localparam int          PIPE_DEPTH  = 265;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] X_SAT_Q20   = 64'd8 << 20;
    localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] activated;
        logic                       last;
    } t_act_beat;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic signed [SAMPLE_W-1:0]  i_sample;
    logic                        i_sample_last;
    logic                        o_valid;
    logic                        i_stall;
    logic signed [SAMPLE_W-1:0]  o_activated;
    logic                        o_activated_last;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_W-1:0]            i_cfg_data;

    logic                        cur_mode;
    logic signed [SAMPLE_W-1:0]  cur_zp;
    logic [CFG_W-1:0]            cur_scale;
    logic [CFG_W-1:0]            cur_inv;

    t_act_beat pending_results[$];
    int        mismatches;
    int        n_samples;
    int        n_results;
    int        n_tanh_samples;
    int        n_reg_writes;
    int        cycles;
    int        burst_left;

    quantized_activation_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample         (i_sample),
        .i_sample_last    (i_sample_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_activated      (o_activated),
        .o_activated_last (o_activated_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic logic [14:0] tanh_q15(input logic [63:0] x_q20);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] a3;
        logic [63:0] a5;
        logic [63:0] t;
        logic [63:0] sq;
        logic [63:0] y;
        a  = x_q20 << 2;
        a2 = (a * a) >> 30;
        a3 = (a2 * a) >> 30;
        a5 = (a3 * a2) >> 30;
        t  = a - a3 / 64'd3 + (64'd2 * a5) / 64'd15;
        if (t >= ONE_Q30) t = ONE_Q30 - 64'd1;
        for (int k = 0; k < DBL_ITERS; k++) begin
            sq = (t * t) >> 30;
            t  = (t << 31) / (ONE_Q30 + sq);
            if (t >= ONE_Q30) t = ONE_Q30 - 64'd1;
        end
        y = (t + 64'd16384) >> 15;
        if (y > 64'd32767) y = 64'd32767;
        return y[14:0];
    endfunction

    function automatic t_act_beat predict_activation(input logic signed [SAMPLE_W-1:0] s,
                                                     input logic l);
        t_act_beat   r;
        int          d;
        int          qs;
        int          sum;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] x;
        logic [63:0] q;
        r.last = l;
        if (cur_mode == MODE_RELU) begin
            r.activated = (s > cur_zp) ? s : cur_zp;
        end else begin
            d   = int'(s) - int'(cur_zp);
            neg = d < 0;
            mag = neg ? 64'(-d) : 64'(d);
            x   = mag * {40'd0, cur_scale};
            if (x > X_SAT_Q20) x = X_SAT_Q20;
            q   = ({49'd0, tanh_q15(x)} * {40'd0, cur_inv} + (64'd1 << 26)) >> 27;
            qs  = neg ? -int'(q) : int'(q);
            sum = qs + int'(cur_zp);
            if (sum > 127) sum = 127;
            if (sum < -128) sum = -128;
            r.activated = sum[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_MODE:  cur_mode  = data[0];
            CFG_ZP:    cur_zp    = data[SAMPLE_W-1:0];
            CFG_SCALE: cur_scale = data;
            CFG_INV:   cur_inv   = data;
            default: ;
        endcase
        n_reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic mode, input logic signed [SAMPLE_W-1:0] zp,
                             input logic [CFG_W-1:0] scale, input logic [CFG_W-1:0] inv);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom);
        write_reg(CFG_MODE, {junk[CFG_W-1:1], mode});
        junk = CFG_W'($urandom);
        write_reg(CFG_ZP, {junk[CFG_W-1:SAMPLE_W], zp});
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_INV, inv);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid       <= 1'b0;
                i_sample      <= SAMPLE_W'($urandom);
                i_sample_last <= 1'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_sample      <= s;
        i_sample_last <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_activation(s, l));
        n_samples++;
        if (cur_mode == MODE_TANH) n_tanh_samples++;
        burst_left--;
    endtask

    // Lowers valid and waits until every beat in flight has come out.
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_relu_reset_values;
        send_sample(-8'sd128, 1'b0);
        send_sample(-8'sd1, 1'b1);
        send_sample(8'sd0, 1'b0);
        send_sample(8'sd1, 1'b0);
        send_sample(8'sd127, 1'b1);
        drain();
    endtask

    task automatic test_relu_zero_point;
        configure(MODE_RELU, -8'sd128, 24'd8192, 24'd524288);
        send_sample(-8'sd128, 1'b1);
        send_sample(8'sd127, 1'b0);
        drain();
        configure(MODE_RELU, 8'sd127, 24'd8192, 24'd524288);
        send_sample(-8'sd128, 1'b0);
        send_sample(8'sd126, 1'b1);
        drain();
    endtask

    task automatic test_tanh_basic;
        configure(MODE_TANH, 8'sd0, 24'd8192, 24'd524288);
        send_sample(-8'sd128, 1'b0);
        send_sample(8'sd127, 1'b1);
        send_sample(8'sd0, 1'b0);
        drain();
    endtask

    task automatic test_tanh_large_argument;
        configure(MODE_TANH, -8'sd128, CFG_MAX, CFG_MAX);
        send_sample(8'sd127, 1'b0);
        send_sample(-8'sd128, 1'b1);
        drain();
        configure(MODE_TANH, 8'sd127, CFG_MAX, CFG_MAX);
        send_sample(-8'sd128, 1'b1);
        drain();
    endtask

    task automatic test_tanh_zero_scale;
        configure(MODE_TANH, 8'sd5, 24'd0, 24'd524288);
        send_sample(-8'sd128, 1'b0);
        send_sample(8'sd127, 1'b1);
        drain();
    endtask

    // With this reciprocal a tie appears whenever the Q0.15 value ends in binary 1000.
    task automatic test_tanh_rounding_ties;
        configure(MODE_TANH, 8'sd0, 24'd3000, 24'd8388608);
        send_sample(8'sd3, 1'b0);
        send_sample(-8'sd7, 1'b0);
        send_sample(8'sd21, 1'b0);
        send_sample(-8'sd45, 1'b0);
        send_sample(8'sd90, 1'b0);
        send_sample(-8'sd33, 1'b1);
        drain();
    endtask

    function automatic logic [CFG_W-1:0] pick_scale;
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return CFG_MAX;
            2:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(1, 70000));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_inv;
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return CFG_MAX;
            2:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(1, 1 << 20));
        endcase
    endfunction

    task automatic test_random_traffic;
        logic                       mode;
        logic signed [SAMPLE_W-1:0] zp;
        logic signed [SAMPLE_W-1:0] s;
        logic [7:0]                 offset;
        int                         n;
        for (int phase = 0; phase < 10; phase++) begin
            mode = (phase % 4 == 0) ? MODE_RELU : MODE_TANH;
            case ($urandom_range(0, 3))
                0:       zp = -8'sd128;
                1:       zp = 8'sd127;
                default: zp = SAMPLE_W'($urandom);
            endcase
            configure(mode, zp, pick_scale(), pick_inv());
            n = $urandom_range(80, 120);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 1) == 0) begin
                    s = SAMPLE_W'($urandom);
                end else begin
                    offset = 8'($urandom_range(0, 40));
                    s = zp + $signed(offset) - 8'sd20;
                end
                send_sample(s, $urandom_range(0, 7) == 0);
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_sample      = '0;
        i_sample_last = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        cur_mode      = RST_MODE;
        cur_zp        = RST_ZP;
        cur_scale     = RST_SCALE;
        cur_inv       = RST_INV;
        mismatches    = 0;
        n_samples     = 0;
        n_results     = 0;
        n_tanh_samples = 0;
        n_reg_writes  = 0;
        burst_left    = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_relu_reset_values();
        test_relu_zero_point();
        test_tanh_basic();
        test_tanh_large_argument();
        test_tanh_zero_scale();
        test_tanh_rounding_ties();
        test_random_traffic();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 40) @(posedge i_clk);
        if (pending_results.size() != 0) mismatches++;

        $display("Checked %0d results for %0d samples, %0d of them through tanh.",
                 n_results, n_samples, n_tanh_samples);
        $display("Used %0d register writes, zero and full-range scales among them.",
                 n_reg_writes);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Output stall pattern: free-flowing, light, heavy or solid stall stretches.
    initial begin
        int stall_mode;
        int stall_left;
        i_stall    = 1'b0;
        stall_mode = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = (stall_mode == 3) ? $urandom_range(1, 40) : $urandom_range(1, 200);
            end
            stall_left--;
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= ($urandom_range(0, 4) != 0);
                default: i_stall <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_act_beat exp_beat;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, actual activated %0d last %0b",
                         $time, o_activated, o_activated_last);
                mismatches++;
            end else begin
                exp_beat = pending_results.pop_front();
                if (o_activated !== exp_beat.activated) begin
                    $display("%0t: activated mismatch, expected %0d actual %0d",
                             $time, exp_beat.activated, o_activated);
                    mismatches++;
                end
                if (o_activated_last !== exp_beat.last) begin
                    $display("%0t: activated_last mismatch, expected %0b actual %0b",
                             $time, exp_beat.last, o_activated_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("%0t: timeout with %0d results outstanding",
                         $time, pending_results.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule

FILE: files.f
hw/rtl/qau_pkg.sv
hw/rtl/qau_front.sv
hw/rtl/qau_dbl_iter.sv
hw/rtl/qau_back.sv
hw/rtl/quantized_activation_unit.sv
tb/sv/quantized_activation_unit_test.sv
